>>> hdl/met_pkg.sv
package met_pkg;

    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_EOF    = 8'h00;

    typedef enum logic [4:0] {
        LV_TOP   = 5'b00001,
        LV_KEY   = 5'b00010,
        LV_VAL   = 5'b00100,
        LV_BRUSH = 5'b01000,
        LV_ERR   = 5'b10000
    } level_t;

    typedef enum logic [5:0] {
        LX_GAP     = 6'b000001,
        LX_SLASH   = 6'b000010,
        LX_COMMENT = 6'b000100,
        LX_BARE    = 6'b001000,
        LX_QUOTE0  = 6'b010000,
        LX_QUOTE   = 6'b100000
    } lexer_t;

    typedef enum logic [3:0] {
        EV_KEYB  = 4'd0,
        EV_KEYE  = 4'd1,
        EV_VALB  = 4'd2,
        EV_VALE  = 4'd3,
        EV_OPEN  = 4'd4,
        EV_CLOSE = 4'd5,
        EV_BRUSH = 4'd6,
        EV_DONE  = 4'd7,
        EV_NOBR  = 4'd8,
        EV_TRUNC = 4'd9
    } event_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] data;
        logic       last;
    } res_t;

    typedef struct packed {
        level_t                  lv;
        lexer_t                  lx;
        logic                    hv;
        logic [7:0]              hc;
        logic [1:0]              n;
        res_t [MAX_RES-1:0]      res;
    } step_t;

    function automatic step_t met_emit(step_t s, event_t ev, logic [7:0] d);
        step_t r;
        r = s;
        if (s.n < 2'(MAX_RES))
        begin
            r.res[s.n].ev   = ev;
            r.res[s.n].data = d;
            r.res[s.n].last = 1'b0;
            r.n             = s.n + 2'd1;
        end
        return r;
    endfunction

    function automatic step_t met_add_char(step_t s, logic [7:0] c, logic first);
        step_t r;
        r = s;
        case (s.lv)
            LV_TOP:
            begin
                if (first)
                begin
                    r.hc = c;
                    r.hv = 1'b1;
                end
                else
                begin
                    r.hv = 1'b0;
                end
            end
            LV_KEY:
            begin
                if (first)
                begin
                    r.hc = c;
                    r.hv = 1'b1;
                end
                else
                begin
                    if (r.hv)
                    begin
                        r    = met_emit(r, EV_KEYB, r.hc);
                        r.hv = 1'b0;
                    end
                    r = met_emit(r, EV_KEYB, c);
                end
            end
            LV_VAL:
            begin
                r = met_emit(r, EV_VALB, c);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic step_t met_end_token(step_t s);
        step_t r;
        r = s;
        case (s.lv)
            LV_TOP:
            begin
                if (s.hv && s.hc == CH_LBRACE)
                begin
                    r    = met_emit(r, EV_OPEN, 8'd0);
                    r.lv = LV_KEY;
                end
                else
                begin
                    r    = met_emit(r, EV_NOBR, 8'd0);
                    r.lv = LV_ERR;
                end
            end
            LV_KEY:
            begin
                if (s.hv && s.hc == CH_RBRACE)
                begin
                    r    = met_emit(r, EV_CLOSE, 8'd0);
                    r.lv = LV_TOP;
                end
                else if (s.hv && s.hc == CH_LBRACE)
                begin
                    r    = met_emit(r, EV_BRUSH, 8'd0);
                    r.lv = LV_BRUSH;
                end
                else
                begin
                    if (s.hv)
                    begin
                        r = met_emit(r, EV_KEYB, s.hc);
                    end
                    r    = met_emit(r, EV_KEYE, 8'd0);
                    r.lv = LV_VAL;
                end
            end
            LV_VAL:
            begin
                r    = met_emit(r, EV_VALE, 8'd0);
                r.lv = LV_KEY;
            end
            default:
            begin
            end
        endcase
        r.lx = LX_GAP;
        r.hv = 1'b0;
        return r;
    endfunction

    function automatic step_t met_step(level_t lv, lexer_t lx, logic hv, logic [7:0] hc,
                                       logic [7:0] c);
        step_t r;
        logic  in_tok;
        r.lv  = lv;
        r.lx  = lx;
        r.hv  = hv;
        r.hc  = hc;
        r.n   = 2'd0;
        r.res = '0;
        in_tok = (lv == LV_TOP) || (lv == LV_KEY) || (lv == LV_VAL);
        if (c == CH_EOF)
        begin
            if (in_tok)
            begin
                if (lx == LX_SLASH)
                begin
                    r = met_add_char(r, CH_SLASH, 1'b1);
                    r = met_end_token(r);
                end
                else if (lx == LX_BARE)
                begin
                    r = met_end_token(r);
                end
            end
            if (!(r.n != 2'd0 && r.lv == LV_ERR))
            begin
                r = met_emit(r, (r.lv == LV_TOP || r.lv == LV_ERR) ? EV_DONE : EV_TRUNC,
                             8'd0);
            end
            r.lv = LV_TOP;
            r.lx = LX_GAP;
            r.hv = 1'b0;
            r.hc = 8'd0;
        end
        else if (lv == LV_BRUSH)
        begin
            if (c == CH_RBRACE)
            begin
                r.lv = LV_KEY;
                r.lx = LX_GAP;
            end
        end
        else if (in_tok)
        begin
            case (lx)
                LX_GAP:
                begin
                    if (c > CH_SPACE)
                    begin
                        if (c == CH_SLASH)
                        begin
                            r.lx = LX_SLASH;
                        end
                        else if (c == CH_QUOTE)
                        begin
                            r.lx = LX_QUOTE0;
                        end
                        else
                        begin
                            r    = met_add_char(r, c, 1'b1);
                            r.lx = LX_BARE;
                        end
                    end
                end
                LX_SLASH:
                begin
                    if (c == CH_SLASH)
                    begin
                        r.lx = LX_COMMENT;
                    end
                    else
                    begin
                        r    = met_add_char(r, CH_SLASH, 1'b1);
                        r.lx = LX_BARE;
                        if (c > CH_SPACE)
                        begin
                            r = met_add_char(r, c, 1'b0);
                        end
                        else
                        begin
                            r = met_end_token(r);
                        end
                    end
                end
                LX_COMMENT:
                begin
                    if (c == CH_NL)
                    begin
                        r.lx = LX_GAP;
                    end
                end
                LX_BARE:
                begin
                    if (c > CH_SPACE)
                    begin
                        r = met_add_char(r, c, 1'b0);
                    end
                    else
                    begin
                        r = met_end_token(r);
                    end
                end
                LX_QUOTE0:
                begin
                    if (c == CH_QUOTE)
                    begin
                        r = met_end_token(r);
                    end
                    else
                    begin
                        r    = met_add_char(r, c, 1'b1);
                        r.lx = LX_QUOTE;
                    end
                end
                LX_QUOTE:
                begin
                    if (c == CH_QUOTE)
                    begin
                        r = met_end_token(r);
                    end
                    else
                    begin
                        r = met_add_char(r, c, 1'b0);
                    end
                end
                default:
                begin
                    r.lx = LX_GAP;
                end
            endcase
        end
        else
        begin
            r.lv = LV_ERR;
        end
        if (r.n != 2'd0)
        begin
            r.res[r.n - 2'd1].last = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> hdl/map_entity_tokenizer.sv
// channel | handshake           | word
// --------+---------------------+-------------------------------
// input   | in_valid / in_ready | byte_req
// output  | out_valid/out_ready | event_res, data_byte, last
//
// one byte enters an input register per cycle while in_ready is high; from there it is
// decoded and its 0 to 3 events are written into a 4-entry result queue.
// a byte is decoded only while the queue has room for 3 events, so output
// stalls back up to in_ready. the output side drains one event per cycle while
// out_ready is high, which sets the rate for bytes that produce several events.
// rst_n clears the lexer state, the input valid flag and the queue pointers and count.
module map_entity_tokenizer
    import met_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_req,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] event_res,
    output logic [7:0] data_byte,
    output logic       last
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    level_t            level_reg;
    lexer_t            lexer_reg;
    logic              held_valid_reg;
    logic [7:0]        held_char_reg;
    res_t              q_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg;
    logic [Q_CW-1:0]   count_next;

    step_t             st;
    logic              proc;
    logic              pop;
    res_t              head;

    always_comb
    begin
        st = met_step(level_reg, lexer_reg, held_valid_reg, held_char_reg, in_byte_reg);
    end

    assign proc       = in_valid_reg && (count_reg <= Q_CW'(Q_DEPTH - MAX_RES));
    assign in_ready   = !in_valid_reg || proc;
    assign pop        = out_valid && out_ready;
    assign count_next = count_reg + (proc ? Q_CW'(st.n) : Q_CW'(0)) - Q_CW'(pop);

    assign head      = q_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign event_res = head.ev;
    assign data_byte = head.data;
    assign last      = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            level_reg      <= LV_TOP;
            lexer_reg      <= LX_GAP;
            held_valid_reg <= 1'b0;
            held_char_reg  <= 8'd0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (proc)
            begin
                level_reg      <= st.lv;
                lexer_reg      <= st.lx;
                held_valid_reg <= st.hv;
                held_char_reg  <= st.hc;
                wr_ptr_reg     <= wr_ptr_reg + Q_AW'(st.n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= byte_req;
        end
        if (proc)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                if (i < int'(st.n))
                begin
                    q_reg[wr_ptr_reg + Q_AW'(i)] <= st.res[i];
                end
            end
        end
    end

endmodule
